[rtl/cva_pkg.sv]
// ----------------------------------------------------------------------------
// Cycle value advance package
// Shared widths, register indexes, reset values and transaction types.
// ----------------------------------------------------------------------------
package cva_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SKIP_WIDTH  = 32;
  localparam int INDEX_WIDTH = 2;

  localparam logic [INDEX_WIDTH-1:0] REG_START_POINT = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_END_POINT   = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_LOOP_ENABLE = 2'd2;

  localparam logic [VALUE_WIDTH-1:0] START_RESET = VALUE_WIDTH'(0);
  localparam logic [VALUE_WIDTH-1:0] END_RESET   = VALUE_WIDTH'(65536);
  localparam logic                   LOOP_RESET  = 1'b1;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] current_value;
    logic signed [VALUE_WIDTH-1:0] advance_step;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] next_value;
    logic                          wrapped;
    logic [SKIP_WIDTH-1:0]         skipped_cycles;
  } result_t;

  typedef struct packed {
    logic                        fwd;
    logic                        ends;
    logic                        over_neg;
    logic                        range_zero;
    logic signed [VALUE_WIDTH:0] sum;
  } side_t;

endpackage

[rtl/cva_div.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a
// side-band word carried alongside each transaction.
// ----------------------------------------------------------------------------
module cva_div #(
  parameter int DVD_W  = cva_pkg::VALUE_WIDTH + 2,
  parameter int DVS_W  = cva_pkg::VALUE_WIDTH + 1,
  parameter int SIDE_W = $bits(cva_pkg::side_t)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              src_valid,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DVS_W-1:0]  divisor,
  input  logic [SIDE_W-1:0] src_side,
  output logic              res_valid,
  output logic [DVD_W-1:0]  quotient,
  output logic [DVS_W-1:0]  remainder,
  output logic [SIDE_W-1:0] res_side
);

  logic              stg_valid [DVD_W];
  logic [DVS_W-1:0]  stg_rem   [DVD_W];
  logic [DVD_W-1:0]  stg_dq    [DVD_W];
  logic [DVS_W-1:0]  stg_dvs   [DVD_W];
  logic [SIDE_W-1:0] stg_side  [DVD_W];

  genvar k;
  generate
    for (k = 0; k < DVD_W; k++) begin : g_stage
      logic              prev_valid;
      logic [DVS_W-1:0]  prev_rem;
      logic [DVD_W-1:0]  prev_dq;
      logic [DVS_W-1:0]  prev_dvs;
      logic [SIDE_W-1:0] prev_side;
      logic [DVS_W:0]    rem_sh;
      logic [DVS_W:0]    diff;
      logic              ge;

      if (k == 0) begin : g_first
        assign prev_valid = src_valid;
        assign prev_rem   = '0;
        assign prev_dq    = dividend;
        assign prev_dvs   = divisor;
        assign prev_side  = src_side;
      end else begin : g_next
        assign prev_valid = stg_valid[k-1];
        assign prev_rem   = stg_rem[k-1];
        assign prev_dq    = stg_dq[k-1];
        assign prev_dvs   = stg_dvs[k-1];
        assign prev_side  = stg_side[k-1];
      end

      assign rem_sh = {prev_rem, prev_dq[DVD_W-1]};
      assign ge     = rem_sh >= {1'b0, prev_dvs};
      assign diff   = rem_sh - {1'b0, prev_dvs};

      always_ff @(posedge clk) begin
        if (rst) begin
          stg_valid[k] <= 1'b0;
        end else if (en) begin
          stg_valid[k] <= prev_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stg_rem[k]  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
          stg_dq[k]   <= {prev_dq[DVD_W-2:0], ge};
          stg_dvs[k]  <= prev_dvs;
          stg_side[k] <= prev_side;
        end
      end
    end
  endgenerate

  assign res_valid = stg_valid[DVD_W-1];
  assign quotient  = stg_dq[DVD_W-1];
  assign remainder = stg_rem[DVD_W-1];
  assign res_side  = stg_side[DVD_W-1];

endmodule

[rtl/cycle_value_advance.sv]
// ----------------------------------------------------------------------------
// Cycle value advance
// Modulo phase accumulator: adds a signed step to a position and wraps the
// result around, or clamps it to, the cycle bounds held in registers.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction on the item channel carries a position and a step. It
// is taken at a clock edge where item_valid is high and item_stall is low.
// Each input transaction yields exactly one transaction on the result channel,
// in order, taken when result_valid is high and result_stall is low.
// The registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while no transaction is in flight (not enforced).
// An accepted transaction passes through registers s1, s2 and s3, the
// divider and s4 to the output register. The divider takes one quotient bit
// per stage and has VALUE_WIDTH + 2 stages.
// Throughput is one transaction per cycle while item_stall is low.
// A stalled result sits in the output register while one more transaction
// moves into a skid register; only then does item_stall rise and the
// pipeline hold, so nothing is lost or repeated.
// Reset empties the pipeline and loads the registers with start 0.0,
// end 1.0 and loop mode on.
// ----------------------------------------------------------------------------
module cycle_value_advance (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  cva_pkg::item_t                        item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output cva_pkg::result_t                      result,
  input  logic                                  cfg_we,
  input  logic [cva_pkg::INDEX_WIDTH-1:0]       cfg_index,
  input  logic [cva_pkg::VALUE_WIDTH-1:0]       cfg_data
);

  localparam int W      = cva_pkg::VALUE_WIDTH;
  localparam int QW     = W + 2;
  localparam int RW     = W + 1;
  localparam int SKIP_W = cva_pkg::SKIP_WIDTH;

  logic signed [W-1:0] start_point;
  logic signed [W-1:0] end_point;
  logic                loop_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_point <= cva_pkg::START_RESET;
      end_point   <= cva_pkg::END_RESET;
      loop_enable <= cva_pkg::LOOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cva_pkg::REG_START_POINT: start_point <= cfg_data;
        cva_pkg::REG_END_POINT:   end_point   <= cfg_data;
        cva_pkg::REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic pipe_en;
  logic skid_valid;
  cva_pkg::result_t skid;

  assign pipe_en    = !skid_valid;
  assign item_stall = skid_valid;

  logic              s1_valid;
  logic signed [W:0] s1_sum;
  logic              s1_fwd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pipe_en) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_sum <= {item.current_value[W-1], item.current_value}
              + {item.advance_step[W-1], item.advance_step};
      s1_fwd <= !item.advance_step[W-1];
    end
  end

  logic                s2_valid;
  logic                s2_fwd;
  logic                s2_ends;
  logic signed [W:0]   s2_sum;
  logic signed [W+1:0] s2_over;
  logic signed [W:0]   s2_range;
  logic signed [W-1:0] s1_bound;
  logic signed [W:0]   s1_bound_x;

  assign s1_bound   = s1_fwd ? end_point : start_point;
  assign s1_bound_x = {s1_bound[W-1], s1_bound};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (pipe_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s2_fwd   <= s1_fwd;
      s2_sum   <= s1_sum;
      s2_ends  <= s1_fwd ? (s1_sum >= s1_bound_x) : (s1_sum <= s1_bound_x);
      s2_over  <= {s1_sum[W], s1_sum} - {s1_bound_x[W], s1_bound_x};
      s2_range <= {end_point[W-1], end_point} - {start_point[W-1], start_point};
    end
  end

  logic              s3_valid;
  logic [QW-1:0]     s3_dividend;
  logic [RW-1:0]     s3_divisor;
  cva_pkg::side_t    s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (pipe_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s3_dividend         <= s2_over[W+1] ? QW'(-s2_over) : QW'(s2_over);
      s3_divisor          <= s2_range[W] ? RW'(-s2_range) : RW'(s2_range);
      s3_side.fwd         <= s2_fwd;
      s3_side.ends        <= s2_ends;
      s3_side.over_neg    <= s2_over[W+1];
      s3_side.range_zero  <= (s2_range == '0);
      s3_side.sum         <= s2_sum;
    end
  end

  logic                          dv_valid;
  logic [QW-1:0]                 dv_quotient;
  logic [RW-1:0]                 dv_remainder;
  logic [$bits(cva_pkg::side_t)-1:0] dv_side_bits;
  cva_pkg::side_t                dv_side;

  cva_div #(
    .DVD_W  (QW),
    .DVS_W  (RW),
    .SIDE_W ($bits(cva_pkg::side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .src_valid (s3_valid),
    .dividend  (s3_dividend),
    .divisor   (s3_divisor),
    .src_side  (s3_side),
    .res_valid (dv_valid),
    .quotient  (dv_quotient),
    .remainder (dv_remainder),
    .res_side  (dv_side_bits)
  );

  assign dv_side = cva_pkg::side_t'(dv_side_bits);

  logic [SKIP_W-1:0] dv_skip;

  generate
    if (QW > SKIP_W) begin : g_skip_sat
      assign dv_skip = (|dv_quotient[QW-1:SKIP_W]) ? '1 : dv_quotient[SKIP_W-1:0];
    end else begin : g_skip_ext
      assign dv_skip = SKIP_W'(dv_quotient);
    end
  endgenerate

  logic                s4_valid;
  cva_pkg::side_t      s4_side;
  logic signed [W+1:0] s4_rem;
  logic [SKIP_W-1:0]   s4_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (pipe_en) begin
      s4_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s4_side <= dv_side;
      s4_skip <= dv_skip;
      s4_rem  <= dv_side.over_neg ? (QW'(0) - {1'b0, dv_remainder})
                                  : {1'b0, dv_remainder};
    end
  end

  logic signed [W-1:0] fin_base;
  logic signed [W+2:0] fin_sum;
  logic signed [W-1:0] fin_sat;
  cva_pkg::result_t    fin;

  assign fin_base = s4_side.fwd ? start_point : end_point;
  assign fin_sum  = {{3{fin_base[W-1]}}, fin_base} + {s4_rem[W+1], s4_rem};

  always_comb begin
    if (fin_sum[W+2:W-1] == '0 || fin_sum[W+2:W-1] == '1) begin
      fin_sat = fin_sum[W-1:0];
    end else if (fin_sum[W+2]) begin
      fin_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      fin_sat = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_comb begin
    fin.next_value     = s4_side.sum[W-1:0];
    fin.wrapped        = 1'b0;
    fin.skipped_cycles = '0;
    if (s4_side.ends) begin
      if (!loop_enable) begin
        fin.next_value = s4_side.fwd ? end_point : start_point;
      end else if (s4_side.range_zero) begin
        fin.next_value = fin_base;
        fin.wrapped    = 1'b1;
      end else begin
        fin.next_value     = fin_sat;
        fin.wrapped        = 1'b1;
        fin.skipped_cycles = s4_skip;
      end
    end
  end

  logic arrive;
  assign arrive = s4_valid && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= arrive;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_valid ? skid : fin;
    end else if (arrive) begin
      skid <= fin;
    end
  end

endmodule
